// ----- design/texel_to_rgba8_converter_macros.svh -----
// assertion macros shared by the texel converter checker
`ifndef TEXEL_TO_RGBA8_CONVERTER_MACROS_SVH
`define TEXEL_TO_RGBA8_CONVERTER_MACROS_SVH

// clocked assertion, masked while reset is active
`define TX2R_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tx2r assertion failed");

// clocked assertion that also holds across reset
`define TX2R_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tx2r assertion failed");

`endif

// ----- design/tx2r_pkg.sv -----
// types, constants and layout decode for the texel to rgba8 converter
package tx2r_pkg;

    // format codes
    localparam logic [7:0] FMT_R8_UNORM           = 8'd9;
    localparam logic [7:0] FMT_R8_SRGB            = 8'd15;
    localparam logic [7:0] FMT_R8G8_UNORM         = 8'd16;
    localparam logic [7:0] FMT_R8G8_SRGB          = 8'd22;
    localparam logic [7:0] FMT_R8G8B8_UNORM       = 8'd23;
    localparam logic [7:0] FMT_R8G8B8_SRGB        = 8'd29;
    localparam logic [7:0] FMT_B8G8R8_UNORM       = 8'd30;
    localparam logic [7:0] FMT_B8G8R8_SRGB        = 8'd36;
    localparam logic [7:0] FMT_R8G8B8A8_UNORM     = 8'd37;
    localparam logic [7:0] FMT_R8G8B8A8_SRGB      = 8'd43;
    localparam logic [7:0] FMT_B8G8R8A8_UNORM     = 8'd44;
    localparam logic [7:0] FMT_B8G8R8A8_SRGB      = 8'd50;
    localparam logic [7:0] FMT_R16_UNORM          = 8'd70;
    localparam logic [7:0] FMT_R16G16_UNORM       = 8'd77;
    localparam logic [7:0] FMT_R16G16B16_UNORM    = 8'd84;
    localparam logic [7:0] FMT_R16G16B16A16_UNORM = 8'd91;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // component count encodings (count minus one)
    localparam logic [1:0] NCOMP_ONE   = 2'd0;
    localparam logic [1:0] NCOMP_TWO   = 2'd1;
    localparam logic [1:0] NCOMP_THREE = 2'd2;
    localparam logic [1:0] NCOMP_FOUR  = 2'd3;

    // smallest 16-bit alpha that converts to 255: 255*257-128
    localparam logic [15:0] ALPHA16_OPAQUE_MIN = 16'd65407;

    // queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    typedef struct packed {
        logic       supported;
        logic       wide;
        logic [1:0] ncomp;
        logic       swapped;
    } t_layout;

    typedef struct packed {
        logic [7:0]  format;
        logic [31:0] pixel_count;
    } t_cfg;

    // one classified texel handed from front to back
    typedef struct packed {
        logic        status;
        logic [63:0] word;
        logic        wide;
        logic [1:0]  ncomp;
        logic        swapped;
        logic        alpha_meaningful;
        logic        last_pixel;
    } t_rec;

    // format code to texel layout
    function automatic t_layout layout_of(input logic [7:0] code);
        t_layout lay;
        lay = '{supported: 1'b1, wide: 1'b0, ncomp: NCOMP_ONE, swapped: 1'b0};
        unique case (code) inside
            FMT_R8_UNORM, FMT_R8_SRGB:             lay.ncomp = NCOMP_ONE;
            FMT_R8G8_UNORM, FMT_R8G8_SRGB:         lay.ncomp = NCOMP_TWO;
            FMT_R8G8B8_UNORM, FMT_R8G8B8_SRGB:     lay.ncomp = NCOMP_THREE;
            FMT_B8G8R8_UNORM, FMT_B8G8R8_SRGB: begin
                lay.ncomp   = NCOMP_THREE;
                lay.swapped = 1'b1;
            end
            FMT_R8G8B8A8_UNORM, FMT_R8G8B8A8_SRGB: lay.ncomp = NCOMP_FOUR;
            FMT_B8G8R8A8_UNORM, FMT_B8G8R8A8_SRGB: begin
                lay.ncomp   = NCOMP_FOUR;
                lay.swapped = 1'b1;
            end
            FMT_R16_UNORM: begin
                lay.ncomp = NCOMP_ONE;
                lay.wide  = 1'b1;
            end
            FMT_R16G16_UNORM: begin
                lay.ncomp = NCOMP_TWO;
                lay.wide  = 1'b1;
            end
            FMT_R16G16B16_UNORM: begin
                lay.ncomp = NCOMP_THREE;
                lay.wide  = 1'b1;
            end
            FMT_R16G16B16A16_UNORM: begin
                lay.ncomp = NCOMP_FOUR;
                lay.wide  = 1'b1;
            end
            default: lay.supported = 1'b0;
        endcase
        return lay;
    endfunction

    // bytes per texel
    function automatic logic [3:0] texel_size(input t_layout lay);
        return ({2'b00, lay.ncomp} + 4'd1) << lay.wide;
    endfunction

endpackage

// ----- design/tx2r_front.sv -----
// front end: gathers bytes into texels, counts pixels, tracks alpha
module tx2r_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_data_byte,
    input  logic           i_start_of_level,
    input  tx2r_pkg::t_cfg i_cfg,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_q_push,
    output tx2r_pkg::t_rec o_q_data
);
    import tx2r_pkg::*;

    logic [55:0] r_held, n_held;
    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_done, n_done;
    logic        r_alpha, n_alpha;

    logic        accept;
    logic        emit;
    logic [55:0] held_eff;
    logic [2:0]  pos_eff;
    logic [31:0] done_eff;
    logic [31:0] done_inc;
    logic        alpha_eff;
    logic        alpha_low;
    t_layout     lay;
    logic [3:0]  size;
    logic [63:0] word;
    t_rec        rec;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // start of level clears everything before the byte is used
    always_comb begin
        held_eff  = i_start_of_level ? '0 : r_held;
        pos_eff   = i_start_of_level ? '0 : r_pos;
        done_eff  = i_start_of_level ? '0 : r_done;
        alpha_eff = i_start_of_level ? 1'b0 : r_alpha;
        lay       = layout_of(i_cfg.format);
        size      = texel_size(lay);
        word      = {8'h00, held_eff} | (64'(i_data_byte) << {pos_eff, 3'b000});
        done_inc  = done_eff + 32'd1;
    end

    // alpha below full scale in the finished texel
    always_comb begin
        alpha_low = 1'b0;
        if (lay.ncomp == NCOMP_FOUR) begin
            alpha_low = lay.wide ? (word[63:48] < ALPHA16_OPAQUE_MIN)
                                 : (word[31:24] != 8'hff);
        end
    end

    // classify the byte and work out the next state
    always_comb begin
        n_held  = held_eff;
        n_pos   = pos_eff;
        n_done  = done_eff;
        n_alpha = alpha_eff;
        emit    = 1'b0;
        rec     = '0;
        if (!lay.supported) begin
            emit       = i_start_of_level;
            rec.status = 1'b1;
        end else if (done_eff >= i_cfg.pixel_count) begin
            emit = 1'b0;
        end else if (({1'b0, pos_eff} + 4'd1) < size) begin
            n_held = word[55:0];
            n_pos  = pos_eff + 3'd1;
        end else begin
            n_held               = '0;
            n_pos                = '0;
            n_done               = done_inc;
            n_alpha              = alpha_eff | alpha_low;
            emit                 = 1'b1;
            rec.word             = word;
            rec.wide             = lay.wide;
            rec.ncomp            = lay.ncomp;
            rec.swapped          = lay.swapped;
            rec.alpha_meaningful = alpha_eff | alpha_low;
            rec.last_pixel       = (done_inc == i_cfg.pixel_count);
        end
    end

    assign o_q_push = accept && emit;
    assign o_q_data = rec;

    // gather state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_pos   <= '0;
            r_done  <= '0;
            r_alpha <= 1'b0;
        end else if (accept) begin
            r_held  <= n_held;
            r_pos   <= n_pos;
            r_done  <= n_done;
            r_alpha <= n_alpha;
        end
    end

endmodule

// ----- design/tx2r_queue.sv -----
// short queue of classified texels between front and back
module tx2r_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tx2r_pkg::t_rec i_data,
    output logic           o_full,
    input  logic           i_pop,
    output tx2r_pkg::t_rec o_data,
    output logic           o_empty
);
    import tx2r_pkg::*;

    t_rec             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QPtrW:0]   r_count;

    assign o_full  = (r_count == (QPtrW + 1)'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/tx2r_back.sv -----
// back end: component conversion, channel mapping and output register
module tx2r_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tx2r_pkg::t_rec i_q_data,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_status,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic [7:0]     o_alpha,
    output logic           o_alpha_meaningful,
    output logic           o_last_pixel
);
    import tx2r_pkg::*;

    // floor(x/257) == (x*65281)>>24 for x below 2^24
    localparam logic [16:0] RECIP_257 = 17'd65281;
    localparam logic [16:0] ROUND_HALF = 17'd128;

    logic       r_valid;
    logic       r_status;
    logic [7:0] r_red, r_green, r_blue, r_alpha;
    logic       r_alpha_meaningful;
    logic       r_last_pixel;

    logic       load;
    logic [7:0] comp [4];
    logic [7:0] n_red, n_green, n_blue, n_alpha;

    // 16-bit unorm to 8-bit: (v+128)/257
    function automatic logic [7:0] narrow16(input logic [15:0] v);
        logic [16:0] x;
        logic [33:0] p;
        x = {1'b0, v} + ROUND_HALF;
        p = 34'(x) * 34'(RECIP_257);
        return p[31:24];
    endfunction

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;

    // per-component extraction
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            comp[i] = i_q_data.wide ? narrow16(i_q_data.word[16*i +: 16])
                                    : i_q_data.word[8*i +: 8];
        end
    end

    // map components onto rgba
    always_comb begin
        n_red   = comp[0];
        n_green = comp[1];
        n_blue  = comp[2];
        n_alpha = 8'hff;
        case (i_q_data.ncomp)
            NCOMP_ONE: begin
                n_green = comp[0];
                n_blue  = comp[0];
            end
            NCOMP_TWO: n_blue = 8'h00;
            default: begin
                if (i_q_data.swapped) begin
                    n_red  = comp[2];
                    n_blue = comp[0];
                end
                if (i_q_data.ncomp == NCOMP_FOUR) begin
                    n_alpha = comp[3];
                end
            end
        endcase
        if (i_q_data.status) begin
            n_red   = 8'h00;
            n_green = 8'h00;
            n_blue  = 8'h00;
            n_alpha = 8'h00;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status           <= i_q_data.status;
            r_red              <= n_red;
            r_green            <= n_green;
            r_blue             <= n_blue;
            r_alpha            <= n_alpha;
            r_alpha_meaningful <= i_q_data.alpha_meaningful;
            r_last_pixel       <= i_q_data.last_pixel;
        end
    end

    assign o_empty            = !r_valid;
    assign o_status           = r_status;
    assign o_red              = r_red;
    assign o_green            = r_green;
    assign o_blue             = r_blue;
    assign o_alpha            = r_alpha;
    assign o_alpha_meaningful = r_alpha_meaningful;
    assign o_last_pixel       = r_last_pixel;

endmodule

// ----- design/texel_to_rgba8_converter.sv -----
// top level of the texel to rgba8 converter
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  bytes in  | i_push / o_full        | i_data_byte, i_start_of_level
//  pixel out | o_empty / i_pop        | o_status, o_red..o_alpha, flags
//  config    | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// one byte accepted per cycle while o_full is low; accepting a texel's last byte
// writes the queue, and the pixel is loaded from there into the output register
// once that register is empty or being popped
// the four-entry queue plus output register absorb output stalls; o_full
// rises only when all of them hold pixels
// reset is synchronous and active low; config is taken every cycle and the
// pixel count product is registered on the write
module texel_to_rgba8_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_level,
    output logic       o_empty,
    input  logic       i_pop,
    output logic       o_status,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha,
    output logic       o_alpha_meaningful,
    output logic       o_last_pixel,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tx2r_pkg::*;

    logic [7:0]  r_format;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_count;

    logic        cfg_wr;
    logic [15:0] height_eff;
    logic [15:0] data_height_eff;
    t_cfg        cfg;
    logic        q_push, q_full, q_pop, q_empty;
    t_rec        q_wr_data, q_rd_data;

    assign o_cfg_ready     = 1'b1;
    assign cfg_wr          = i_cfg_valid && o_cfg_ready;
    assign height_eff      = (r_height == '0) ? 16'd1 : r_height;
    assign data_height_eff = (i_cfg_data == '0) ? 16'd1 : i_cfg_data;

    // configuration registers and pixel count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= '0;
            r_width  <= 16'd1;
            r_height <= '0;
            r_count  <= 32'd1;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_FORMAT: r_format <= i_cfg_data[7:0];
                REG_WIDTH: begin
                    r_width <= i_cfg_data;
                    r_count <= {16'h0000, i_cfg_data} * {16'h0000, height_eff};
                end
                REG_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_count  <= {16'h0000, r_width} * {16'h0000, data_height_eff};
                end
                default: r_format <= r_format;
            endcase
        end
    end

    assign cfg.format      = r_format;
    assign cfg.pixel_count = r_count;

    tx2r_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_data_byte      (i_data_byte),
        .i_start_of_level (i_start_of_level),
        .i_cfg            (cfg),
        .i_q_full         (q_full),
        .o_full           (o_full),
        .o_q_push         (q_push),
        .o_q_data         (q_wr_data)
    );

    tx2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    tx2r_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_data           (q_rd_data),
        .i_q_empty          (q_empty),
        .o_q_pop            (q_pop),
        .i_pop              (i_pop),
        .o_empty            (o_empty),
        .o_status           (o_status),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .o_alpha            (o_alpha),
        .o_alpha_meaningful (o_alpha_meaningful),
        .o_last_pixel       (o_last_pixel)
    );

endmodule

// ----- design/tx2r_checker.sv -----
// port-level checker for the texel converter, bound to the top level
`include "texel_to_rgba8_converter_macros.svh"

module tx2r_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_empty,
    input logic       i_pop,
    input logic       o_status,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic [7:0] o_alpha,
    input logic       o_alpha_meaningful,
    input logic       o_last_pixel
);

    // nothing waits on the output right after reset
    `TX2R_ASSERT_NORST(a_empty_after_reset, i_clk, !i_rst_n |=> o_empty)

    // a waiting transaction holds its status, red, alpha and last-pixel flag until popped
    `TX2R_ASSERT(a_result_holds, i_clk, i_rst_n, !o_empty && !i_pop |=> !o_empty && $stable(o_status) && $stable(o_red) && $stable(o_alpha) && $stable(o_last_pixel))

    // an error transaction carries an all-zero pixel and flags
    `TX2R_ASSERT(a_error_zero, i_clk, i_rst_n, !o_empty && o_status |-> o_red == 8'h00 && o_green == 8'h00 && o_blue == 8'h00 && o_alpha == 8'h00 && !o_alpha_meaningful && !o_last_pixel)

    // a translucent pixel always sets the sticky alpha flag
    `TX2R_ASSERT(a_alpha_sticky, i_clk, i_rst_n, !o_empty && !o_status && o_alpha != 8'hff |-> o_alpha_meaningful)

endmodule

bind texel_to_rgba8_converter tx2r_checker u_tx2r_checker (.*);
